>>> hdl/spmd_pkg.sv
// Package for the segment pair minimum distance block: widths, stage indices,
// payload types and the arithmetic steps shared by the pipeline.
// No dependencies.
`default_nettype none

package spmd_pkg;

    localparam int COORD_WIDTH     = 24;
    localparam int PARAM_FRAC_BITS = 24;
    localparam int DIST_WIDTH      = 25;

    // difference vectors, single products and dot products
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int DOT_W  = PROD_W + 2;
    localparam int XD_W   = DOT_W + 1;
    // closest point component w*2^P + u*s - v*t
    localparam int COMP_W = DIFF_W + PARAM_FRAC_BITS + 2;
    // split multiplier operand and product
    localparam int MUL_W  = (DOT_W > COMP_W) ? DOT_W : COMP_W;
    localparam int LO_W   = MUL_W / 2;
    localparam int HI_W   = MUL_W - LO_W;
    localparam int MP_W   = 2 * MUL_W;
    // numerators and denominators of s and t, their quotients and the scaled products
    localparam int BIG_W  = 2 * DOT_W + 1;
    localparam int Q_W    = PARAM_FRAC_BITS + 1;
    localparam int PM_W   = DIFF_W + Q_W + 1;
    // squared distance and root operand
    localparam int SQ_W   = MP_W + 2;
    localparam int S_W    = SQ_W - 2 * PARAM_FRAC_BITS;
    localparam int RT_W   = 2 * DIST_WIDTH;
    localparam int SX_W   = ((S_W > RT_W) ? S_W : RT_W) + 1;

    // stage indices of the valid line
    localparam int IX_DIV0 = 8;
    localparam int IX_DIVN = IX_DIV0 + PARAM_FRAC_BITS;
    localparam int IX_RT0  = IX_DIVN + 5;
    localparam int IX_RTN  = IX_RT0 + DIST_WIDTH;
    localparam int N_ST    = IX_RTN + 2;

    typedef struct packed {
        logic signed [2*HI_W-1:0]    hh;
        logic signed [HI_W+LO_W:0]   hl;
        logic signed [HI_W+LO_W:0]   lh;
        logic        [2*LO_W-1:0]    ll;
    } t_pp;

    typedef struct packed {
        logic [2:0][DIFF_W-1:0] u;
        logic [2:0][DIFF_W-1:0] v;
        logic [2:0][DIFF_W-1:0] w;
    } t_geo;

    typedef struct packed {
        logic signed [XD_W-1:0] x1;
        logic signed [XD_W-1:0] x2;
        logic                   x1n;
        logic                   x1g;
        logic                   x2n;
        logic                   x2g;
    } t_xs;

    typedef struct packed {
        logic [BIG_W-1:0] rem;
        logic [BIG_W-1:0] den;
        logic [Q_W-1:0]   q;
        logic             fz;
        logic             fo;
    } t_div;

    typedef struct packed {
        logic [RT_W-1:0] x;
        logic [RT_W-1:0] res;
        logic            big;
    } t_rt;

    // partial products of a split signed multiply
    function automatic t_pp pp_mul(input logic signed [MUL_W-1:0] x,
                                   input logic signed [MUL_W-1:0] y);
        t_pp                    p;
        logic signed [HI_W-1:0] xh;
        logic signed [HI_W-1:0] yh;
        logic signed [LO_W:0]   xl;
        logic signed [LO_W:0]   yl;
        xh   = x[MUL_W-1:LO_W];
        yh   = y[MUL_W-1:LO_W];
        xl   = {1'b0, x[LO_W-1:0]};
        yl   = {1'b0, y[LO_W-1:0]};
        p.hh = xh * yh;
        p.hl = xh * yl;
        p.lh = xl * yh;
        p.ll = x[LO_W-1:0] * y[LO_W-1:0];
        return p;
    endfunction

    function automatic logic signed [MP_W-1:0] pp_sum(input t_pp p);
        logic signed [MP_W-1:0] hh;
        logic signed [MP_W-1:0] mid;
        logic signed [MP_W-1:0] ll;
        hh  = MP_W'($signed(p.hh)) <<< (2 * LO_W);
        mid = (MP_W'($signed(p.hl)) + MP_W'($signed(p.lh))) <<< LO_W;
        ll  = $signed(MP_W'(p.ll));
        return hh + mid + ll;
    endfunction

    // one restoring quotient bit
    function automatic t_div div_step(input t_div d);
        t_div             n;
        logic [BIG_W-1:0] sh;
        logic             ge;
        n     = d;
        sh    = {d.rem[BIG_W-2:0], 1'b0};
        ge    = (sh >= d.den);
        n.rem = ge ? (sh - d.den) : sh;
        n.q   = {d.q[Q_W-2:0], ge};
        return n;
    endfunction

    // one root bit, trial bit 4^e
    function automatic t_rt rt_step(input t_rt s, input int e);
        t_rt             n;
        logic [RT_W-1:0] bt;
        logic [RT_W-1:0] tr;
        n  = s;
        bt = {{(RT_W-1){1'b0}}, 1'b1} << (2 * e);
        tr = s.res + bt;
        if (s.x >= tr) begin
            n.x   = s.x - tr;
            n.res = (s.res >> 1) + bt;
        end else begin
            n.res = s.res >> 1;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

>>> hdl/segment_pair_min_distance.sv
// Shortest distance between two 3D segments, fully pipelined.
// Depends on spmd_pkg for widths, stage indices, types and step functions.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  input   | in        | i_valid / o_stall  | i_seg_{a,b}_{start,end}_{x,y,z}
//  output  | out       | o_valid / i_stall  | o_min_distance
//
// One segment pair enters per cycle while the output is not stalled, through 64 register
// stages; the depth is set mostly by the 24 quotient stages of the two parallel dividers
// and the 25 stages of the root.
// Reset clears the valid line only; payload registers hold whatever they had.
// A stalled output register freezes the whole pipeline and raises o_stall in
// the same cycle, so no request is dropped or repeated.
`default_nettype none

module segment_pair_min_distance (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_stall,
    input  wire logic signed [spmd_pkg::COORD_WIDTH-1:0] i_seg_a_start_x,
    input  wire logic signed [spmd_pkg::COORD_WIDTH-1:0] i_seg_a_start_y,
    input  wire logic signed [spmd_pkg::COORD_WIDTH-1:0] i_seg_a_start_z,
    input  wire logic signed [spmd_pkg::COORD_WIDTH-1:0] i_seg_a_end_x,
    input  wire logic signed [spmd_pkg::COORD_WIDTH-1:0] i_seg_a_end_y,
    input  wire logic signed [spmd_pkg::COORD_WIDTH-1:0] i_seg_a_end_z,
    input  wire logic signed [spmd_pkg::COORD_WIDTH-1:0] i_seg_b_start_x,
    input  wire logic signed [spmd_pkg::COORD_WIDTH-1:0] i_seg_b_start_y,
    input  wire logic signed [spmd_pkg::COORD_WIDTH-1:0] i_seg_b_start_z,
    input  wire logic signed [spmd_pkg::COORD_WIDTH-1:0] i_seg_b_end_x,
    input  wire logic signed [spmd_pkg::COORD_WIDTH-1:0] i_seg_b_end_y,
    input  wire logic signed [spmd_pkg::COORD_WIDTH-1:0] i_seg_b_end_z,
    output logic                                        o_valid,
    input  wire logic                                   i_stall,
    output logic [spmd_pkg::DIST_WIDTH-1:0]             o_min_distance
);

    logic                                   adv;
    logic [spmd_pkg::N_ST-1:0]              r_vld;

    logic signed [spmd_pkg::COORD_WIDTH-1:0] pa0 [3];
    logic signed [spmd_pkg::COORD_WIDTH-1:0] pa1 [3];
    logic signed [spmd_pkg::COORD_WIDTH-1:0] pb0 [3];
    logic signed [spmd_pkg::COORD_WIDTH-1:0] pb1 [3];

    spmd_pkg::t_geo                         r_geo [spmd_pkg::IX_DIVN+1];

    logic signed [spmd_pkg::PROD_W-1:0]     r2_uu [3];
    logic signed [spmd_pkg::PROD_W-1:0]     r2_uv [3];
    logic signed [spmd_pkg::PROD_W-1:0]     r2_vv [3];
    logic signed [spmd_pkg::PROD_W-1:0]     r2_uw [3];
    logic signed [spmd_pkg::PROD_W-1:0]     r2_vw [3];

    logic signed [spmd_pkg::DOT_W-1:0]      r3_a, r3_b, r3_c, r3_d, r3_e;

    spmd_pkg::t_pp                          r4_ac, r4_bb, r4_be, r4_cd, r4_ae, r4_bd;
    logic signed [spmd_pkg::DOT_W-1:0]      r4_a, r4_b, r4_c, r4_e;
    spmd_pkg::t_xs                          r4_xs;
    spmd_pkg::t_xs                          n4_xs;

    logic signed [spmd_pkg::MP_W-1:0]       r5_ac, r5_bb, r5_be, r5_cd, r5_ae, r5_bd;
    logic signed [spmd_pkg::DOT_W-1:0]      r5_a, r5_b, r5_c, r5_e;
    spmd_pkg::t_xs                          r5_xs;

    logic signed [spmd_pkg::BIG_W-1:0]      r6_dd, r6_sn, r6_tn;
    logic signed [spmd_pkg::DOT_W-1:0]      r6_a, r6_b, r6_c, r6_e;
    spmd_pkg::t_xs                          r6_xs;

    logic signed [spmd_pkg::BIG_W-1:0]      r7_sn, r7_sd, r7_tn, r7_td;
    logic signed [spmd_pkg::BIG_W-1:0]      n7_sn, n7_sd, n7_tn, n7_td;
    logic signed [spmd_pkg::DOT_W-1:0]      r7_a;
    spmd_pkg::t_xs                          r7_xs;

    logic signed [spmd_pkg::BIG_W-1:0]      r8_sn, r8_sd, r8_tn, r8_td;
    logic signed [spmd_pkg::BIG_W-1:0]      n8_sn, n8_sd, n8_tn, n8_td;

    spmd_pkg::t_div                         r_sdiv [spmd_pkg::PARAM_FRAC_BITS+1];
    spmd_pkg::t_div                         r_tdiv [spmd_pkg::PARAM_FRAC_BITS+1];
    spmd_pkg::t_div                         n_sdiv0, n_tdiv0;
    logic [spmd_pkg::Q_W-1:0]               sc, tc;

    logic signed [spmd_pkg::PM_W-1:0]       r_cu [3];
    logic signed [spmd_pkg::PM_W-1:0]       r_cv [3];
    logic signed [spmd_pkg::DIFF_W-1:0]     r_cw [3];
    logic signed [spmd_pkg::COMP_W-1:0]     r_comp [3];
    spmd_pkg::t_pp                          r_pq [3];
    logic signed [spmd_pkg::MP_W-1:0]       r_sq [3];

    logic [spmd_pkg::SQ_W-1:0]              sq_sum;
    logic [spmd_pkg::SX_W-1:0]              sq_sh;
    spmd_pkg::t_rt                          n_rt0;
    spmd_pkg::t_rt                          r_rt [spmd_pkg::DIST_WIDTH+1];
    logic [spmd_pkg::DIST_WIDTH-1:0]        r_dist;

    // hold every stage while the output register is full and stalled
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_vld[spmd_pkg::N_ST-1];
    assign o_min_distance = r_dist;

    assign pa0[0] = i_seg_a_start_x;
    assign pa0[1] = i_seg_a_start_y;
    assign pa0[2] = i_seg_a_start_z;
    assign pa1[0] = i_seg_a_end_x;
    assign pa1[1] = i_seg_a_end_y;
    assign pa1[2] = i_seg_a_end_z;
    assign pb0[0] = i_seg_b_start_x;
    assign pb0[1] = i_seg_b_start_y;
    assign pb0[2] = i_seg_b_start_z;
    assign pb1[0] = i_seg_b_end_x;
    assign pb1[1] = i_seg_b_end_y;
    assign pb1[2] = i_seg_b_end_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[spmd_pkg::N_ST-2:0], i_valid};
        end
    end

    // candidate s values for the t clamp: -d and b-d against a
    always_comb begin
        n4_xs.x1  = -spmd_pkg::XD_W'(r3_d);
        n4_xs.x2  = spmd_pkg::XD_W'(r3_b) - spmd_pkg::XD_W'(r3_d);
        n4_xs.x1n = (n4_xs.x1 < 0);
        n4_xs.x2n = (n4_xs.x2 < 0);
        n4_xs.x1g = (n4_xs.x1 > spmd_pkg::XD_W'(r3_a));
        n4_xs.x2g = (n4_xs.x2 > spmd_pkg::XD_W'(r3_a));
    end

    // clamp s, recompute t on the matching edge
    always_comb begin
        n7_sn = r6_sn;
        n7_sd = r6_dd;
        n7_tn = r6_tn;
        n7_td = r6_dd;
        if (r6_dd <= 0) begin
            n7_sn = '0;
            n7_sd = spmd_pkg::BIG_W'(1);
            n7_tn = spmd_pkg::BIG_W'(r6_e);
            n7_td = spmd_pkg::BIG_W'(r6_c);
        end else if (r6_sn < 0) begin
            n7_sn = '0;
            n7_tn = spmd_pkg::BIG_W'(r6_e);
            n7_td = spmd_pkg::BIG_W'(r6_c);
        end else if (r6_sn > r6_dd) begin
            n7_sn = r6_dd;
            n7_tn = spmd_pkg::BIG_W'(r6_e) + spmd_pkg::BIG_W'(r6_b);
            n7_td = spmd_pkg::BIG_W'(r6_c);
        end
    end

    // clamp t, recompute s where t left its range
    always_comb begin
        n8_sn = r7_sn;
        n8_sd = r7_sd;
        n8_tn = r7_tn;
        n8_td = r7_td;
        if (r7_tn < 0) begin
            n8_tn = '0;
            if (r7_xs.x1n) begin
                n8_sn = '0;
            end else if (!r7_xs.x1g) begin
                n8_sn = spmd_pkg::BIG_W'(r7_xs.x1);
                n8_sd = spmd_pkg::BIG_W'(r7_a);
            end else begin
                n8_sn = r7_sd;
            end
        end else if (r7_tn > r7_td) begin
            n8_tn = r7_td;
            if (r7_xs.x2n) begin
                n8_sn = '0;
            end else if (!r7_xs.x2g) begin
                n8_sn = spmd_pkg::BIG_W'(r7_xs.x2);
                n8_sd = spmd_pkg::BIG_W'(r7_a);
            end else begin
                n8_sn = r7_sd;
            end
        end
    end

    // divider set-up: zero and full-scale results bypass the quotient
    always_comb begin
        n_sdiv0.rem = r8_sn;
        n_sdiv0.den = r8_sd;
        n_sdiv0.q   = '0;
        n_sdiv0.fz  = (r8_sn <= 0) || (r8_sd <= 0);
        n_sdiv0.fo  = !n_sdiv0.fz && (r8_sn >= r8_sd);
        n_tdiv0.rem = r8_tn;
        n_tdiv0.den = r8_td;
        n_tdiv0.q   = '0;
        n_tdiv0.fz  = (r8_tn <= 0) || (r8_td <= 0);
        n_tdiv0.fo  = !n_tdiv0.fz && (r8_tn >= r8_td);
    end

    always_comb begin
        if (r_sdiv[spmd_pkg::PARAM_FRAC_BITS].fo) begin
            sc = spmd_pkg::Q_W'(1) << spmd_pkg::PARAM_FRAC_BITS;
        end else if (r_sdiv[spmd_pkg::PARAM_FRAC_BITS].fz) begin
            sc = '0;
        end else begin
            sc = r_sdiv[spmd_pkg::PARAM_FRAC_BITS].q;
        end
        if (r_tdiv[spmd_pkg::PARAM_FRAC_BITS].fo) begin
            tc = spmd_pkg::Q_W'(1) << spmd_pkg::PARAM_FRAC_BITS;
        end else if (r_tdiv[spmd_pkg::PARAM_FRAC_BITS].fz) begin
            tc = '0;
        end else begin
            tc = r_tdiv[spmd_pkg::PARAM_FRAC_BITS].q;
        end
    end

    // drop the 2P fraction bits, flag anything beyond the root range
    always_comb begin
        sq_sum = spmd_pkg::SQ_W'(r_sq[0]) + spmd_pkg::SQ_W'(r_sq[1])
               + spmd_pkg::SQ_W'(r_sq[2]);
        sq_sh  = spmd_pkg::SX_W'(sq_sum[spmd_pkg::SQ_W-1:2*spmd_pkg::PARAM_FRAC_BITS]);
        n_rt0.x   = sq_sh[spmd_pkg::RT_W-1:0];
        n_rt0.res = '0;
        n_rt0.big = |sq_sh[spmd_pkg::SX_W-1:spmd_pkg::RT_W];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_geo[0].u[i] <= spmd_pkg::DIFF_W'(pa1[i]) - spmd_pkg::DIFF_W'(pa0[i]);
                r_geo[0].v[i] <= spmd_pkg::DIFF_W'(pb1[i]) - spmd_pkg::DIFF_W'(pb0[i]);
                r_geo[0].w[i] <= spmd_pkg::DIFF_W'(pa0[i]) - spmd_pkg::DIFF_W'(pb0[i]);
            end
            for (int k = 1; k <= spmd_pkg::IX_DIVN; k++) begin
                r_geo[k] <= r_geo[k-1];
            end

            for (int i = 0; i < 3; i++) begin
                r2_uu[i] <= $signed(r_geo[0].u[i]) * $signed(r_geo[0].u[i]);
                r2_uv[i] <= $signed(r_geo[0].u[i]) * $signed(r_geo[0].v[i]);
                r2_vv[i] <= $signed(r_geo[0].v[i]) * $signed(r_geo[0].v[i]);
                r2_uw[i] <= $signed(r_geo[0].u[i]) * $signed(r_geo[0].w[i]);
                r2_vw[i] <= $signed(r_geo[0].v[i]) * $signed(r_geo[0].w[i]);
            end

            r3_a <= spmd_pkg::DOT_W'(r2_uu[0]) + spmd_pkg::DOT_W'(r2_uu[1])
                  + spmd_pkg::DOT_W'(r2_uu[2]);
            r3_b <= spmd_pkg::DOT_W'(r2_uv[0]) + spmd_pkg::DOT_W'(r2_uv[1])
                  + spmd_pkg::DOT_W'(r2_uv[2]);
            r3_c <= spmd_pkg::DOT_W'(r2_vv[0]) + spmd_pkg::DOT_W'(r2_vv[1])
                  + spmd_pkg::DOT_W'(r2_vv[2]);
            r3_d <= spmd_pkg::DOT_W'(r2_uw[0]) + spmd_pkg::DOT_W'(r2_uw[1])
                  + spmd_pkg::DOT_W'(r2_uw[2]);
            r3_e <= spmd_pkg::DOT_W'(r2_vw[0]) + spmd_pkg::DOT_W'(r2_vw[1])
                  + spmd_pkg::DOT_W'(r2_vw[2]);

            r4_ac <= spmd_pkg::pp_mul(spmd_pkg::MUL_W'(r3_a), spmd_pkg::MUL_W'(r3_c));
            r4_bb <= spmd_pkg::pp_mul(spmd_pkg::MUL_W'(r3_b), spmd_pkg::MUL_W'(r3_b));
            r4_be <= spmd_pkg::pp_mul(spmd_pkg::MUL_W'(r3_b), spmd_pkg::MUL_W'(r3_e));
            r4_cd <= spmd_pkg::pp_mul(spmd_pkg::MUL_W'(r3_c), spmd_pkg::MUL_W'(r3_d));
            r4_ae <= spmd_pkg::pp_mul(spmd_pkg::MUL_W'(r3_a), spmd_pkg::MUL_W'(r3_e));
            r4_bd <= spmd_pkg::pp_mul(spmd_pkg::MUL_W'(r3_b), spmd_pkg::MUL_W'(r3_d));
            r4_a  <= r3_a;
            r4_b  <= r3_b;
            r4_c  <= r3_c;
            r4_e  <= r3_e;
            r4_xs <= n4_xs;

            r5_ac <= spmd_pkg::pp_sum(r4_ac);
            r5_bb <= spmd_pkg::pp_sum(r4_bb);
            r5_be <= spmd_pkg::pp_sum(r4_be);
            r5_cd <= spmd_pkg::pp_sum(r4_cd);
            r5_ae <= spmd_pkg::pp_sum(r4_ae);
            r5_bd <= spmd_pkg::pp_sum(r4_bd);
            r5_a  <= r4_a;
            r5_b  <= r4_b;
            r5_c  <= r4_c;
            r5_e  <= r4_e;
            r5_xs <= r4_xs;

            r6_dd <= spmd_pkg::BIG_W'(r5_ac) - spmd_pkg::BIG_W'(r5_bb);
            r6_sn <= spmd_pkg::BIG_W'(r5_be) - spmd_pkg::BIG_W'(r5_cd);
            r6_tn <= spmd_pkg::BIG_W'(r5_ae) - spmd_pkg::BIG_W'(r5_bd);
            r6_a  <= r5_a;
            r6_b  <= r5_b;
            r6_c  <= r5_c;
            r6_e  <= r5_e;
            r6_xs <= r5_xs;

            r7_sn <= n7_sn;
            r7_sd <= n7_sd;
            r7_tn <= n7_tn;
            r7_td <= n7_td;
            r7_a  <= r6_a;
            r7_xs <= r6_xs;

            r8_sn <= n8_sn;
            r8_sd <= n8_sd;
            r8_tn <= n8_tn;
            r8_td <= n8_td;

            r_sdiv[0] <= n_sdiv0;
            r_tdiv[0] <= n_tdiv0;
            for (int k = 1; k <= spmd_pkg::PARAM_FRAC_BITS; k++) begin
                r_sdiv[k] <= spmd_pkg::div_step(r_sdiv[k-1]);
                r_tdiv[k] <= spmd_pkg::div_step(r_tdiv[k-1]);
            end

            for (int i = 0; i < 3; i++) begin
                r_cu[i] <= $signed(r_geo[spmd_pkg::IX_DIVN].u[i]) * $signed({1'b0, sc});
                r_cv[i] <= $signed(r_geo[spmd_pkg::IX_DIVN].v[i]) * $signed({1'b0, tc});
                r_cw[i] <= r_geo[spmd_pkg::IX_DIVN].w[i];
                r_comp[i] <= (spmd_pkg::COMP_W'(r_cw[i]) <<< spmd_pkg::PARAM_FRAC_BITS)
                           + spmd_pkg::COMP_W'(r_cu[i]) - spmd_pkg::COMP_W'(r_cv[i]);
                r_pq[i] <= spmd_pkg::pp_mul(spmd_pkg::MUL_W'(r_comp[i]),
                                            spmd_pkg::MUL_W'(r_comp[i]));
                r_sq[i] <= spmd_pkg::pp_sum(r_pq[i]);
            end

            r_rt[0] <= n_rt0;
            for (int k = 1; k <= spmd_pkg::DIST_WIDTH; k++) begin
                r_rt[k] <= spmd_pkg::rt_step(r_rt[k-1], spmd_pkg::DIST_WIDTH - k);
            end

            // saturate out-of-range distances
            r_dist <= r_rt[spmd_pkg::DIST_WIDTH].big ? '1
                    : r_rt[spmd_pkg::DIST_WIDTH].res[spmd_pkg::DIST_WIDTH-1:0];
        end
    end

`ifndef SYNTHESIS
    a_hold_when_stalled : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_vld))
        else $error("valid line moved during a stall");

    a_div_remainder : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[spmd_pkg::IX_DIVN] && !r_sdiv[spmd_pkg::PARAM_FRAC_BITS].fz
         && !r_sdiv[spmd_pkg::PARAM_FRAC_BITS].fo)
        |-> (r_sdiv[spmd_pkg::PARAM_FRAC_BITS].rem < r_sdiv[spmd_pkg::PARAM_FRAC_BITS].den))
        else $error("s divider remainder not below divisor");

    a_root_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[spmd_pkg::IX_RTN] && !r_rt[spmd_pkg::DIST_WIDTH].big)
        |-> (r_rt[spmd_pkg::DIST_WIDTH].res[spmd_pkg::RT_W-1:spmd_pkg::DIST_WIDTH] == '0))
        else $error("root exceeds distance width");
`endif

endmodule

`default_nettype wire

>>> test/segment_pair_min_distance_checker.sv
// Checker for segment_pair_min_distance: predicts each distance from the accepted pair
// and compares it with the results, oldest first.
// Depends on spmd_pkg for the coordinate, fraction and distance widths.
`timescale 1ns / 100ps

module segment_pair_min_distance_checker (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_valid,
    input  logic                                            i_in_stall,
    input  logic [11:0][spmd_pkg::COORD_WIDTH-1:0]          i_pair,
    input  logic                                            i_out_valid,
    input  logic                                            i_out_stall,
    input  logic [spmd_pkg::DIST_WIDTH-1:0]                 i_min_distance,
    output int                                              o_fail_count,
    output int                                              o_pending,
    output int                                              o_checked
);
    typedef logic signed [255:0] t_wide;
    localparam int PF = spmd_pkg::PARAM_FRAC_BITS;
    localparam int DW = spmd_pkg::DIST_WIDTH;

    logic [DW-1:0] distances_due[$];

    assign o_pending = distances_due.size();

    function automatic t_wide clamped_ratio(input t_wide num, input t_wide den);
        if (num <= 0 || den <= 0) return 0;
        if (num >= den) return t_wide'(1) <<< PF;
        return (num <<< PF) / den;
    endfunction

    function automatic logic [63:0] int_root(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bt;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > x) bt = bt >> 2;
        while (bt != 0) begin
            if (x >= res + bt) begin
                x   = x - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic logic [DW-1:0] closest_distance(
        input logic [11:0][spmd_pkg::COORD_WIDTH-1:0] p);
        t_wide u[3], v[3], w[3];
        t_wide a, b, c, d, e, dd, sn, sd, tn, td, x, sc, tc, comp, sum, sq;
        logic signed [spmd_pkg::COORD_WIDTH-1:0] a0, a1, b0, b1;
        for (int i = 0; i < 3; i++) begin
            a0 = p[i]; a1 = p[3+i]; b0 = p[6+i]; b1 = p[9+i];
            u[i] = t_wide'(a1) - t_wide'(a0);
            v[i] = t_wide'(b1) - t_wide'(b0);
            w[i] = t_wide'(a0) - t_wide'(b0);
        end
        a = u[0]*u[0] + u[1]*u[1] + u[2]*u[2];
        b = u[0]*v[0] + u[1]*v[1] + u[2]*v[2];
        c = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
        d = u[0]*w[0] + u[1]*w[1] + u[2]*w[2];
        e = v[0]*w[0] + v[1]*w[1] + v[2]*w[2];
        dd = a*c - b*b;
        if (dd <= 0) begin
            // parallel or degenerate: pin s at the start of A
            sn = 0; sd = 1; tn = e; td = c;
        end else begin
            sn = b*e - c*d; tn = a*e - b*d; sd = dd; td = dd;
            if (sn < 0) begin
                sn = 0; tn = e; td = c;
            end else if (sn > sd) begin
                sn = sd; tn = e + b; td = c;
            end
        end
        if (tn < 0) begin
            x = -d; tn = 0;
            if (x < 0) sn = 0;
            else if (x > a) sn = sd;
            else begin sn = x; sd = a; end
        end else if (tn > td) begin
            x = b - d; tn = td;
            if (x < 0) sn = 0;
            else if (x > a) sn = sd;
            else begin sn = x; sd = a; end
        end
        sc = clamped_ratio(sn, sd);
        tc = clamped_ratio(tn, td);
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            comp = (w[i] <<< PF) + u[i]*sc - v[i]*tc;
            sum  = sum + comp*comp;
        end
        sq = sum >>> (2*PF);
        if (sq >= (t_wide'(1) <<< (2*DW))) return {DW{1'b1}};
        return DW'(int_root(sq[63:0]));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_checked    <= 0;
        end else begin
            if (i_valid && !i_in_stall)
                distances_due.push_back(closest_distance(i_pair));
            if (i_out_valid && !i_out_stall) begin
                o_checked <= o_checked + 1;
                if (distances_due.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result: distance %0d", i_min_distance);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    if (distances_due[0] !== i_min_distance) begin
                        if (o_fail_count < 10)
                            $display("distance mismatch: expected %0d, got %0d",
                                     distances_due[0], i_min_distance);
                        o_fail_count <= o_fail_count + 1;
                    end
                    void'(distances_due.pop_front());
                end
            end
        end
    end

endmodule

>>> test/testbench.sv
// Top of the testbench for segment_pair_min_distance: clock, reset, segment pair
// stimulus and output stalls; the checker does prediction and comparison.
// Depends on spmd_pkg, segment_pair_min_distance and segment_pair_min_distance_checker.
`timescale 1ns / 100ps

module testbench;
    localparam int CW = spmd_pkg::COORD_WIDTH;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [11:0][CW-1:0]   pair_q;
    logic                  o_valid;
    logic                  i_stall;
    logic [spmd_pkg::DIST_WIDTH-1:0] o_min_distance;
    int                    fail_count;
    int                    pending;
    int                    checked;
    int                    idle_mode;
    logic                  hold_req;
    int                    pairs_sent;

    segment_pair_min_distance u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_seg_a_start_x(pair_q[0]), .i_seg_a_start_y(pair_q[1]),
        .i_seg_a_start_z(pair_q[2]), .i_seg_a_end_x(pair_q[3]),
        .i_seg_a_end_y(pair_q[4]), .i_seg_a_end_z(pair_q[5]),
        .i_seg_b_start_x(pair_q[6]), .i_seg_b_start_y(pair_q[7]),
        .i_seg_b_start_z(pair_q[8]), .i_seg_b_end_x(pair_q[9]),
        .i_seg_b_end_y(pair_q[10]), .i_seg_b_end_z(pair_q[11]),
        .o_valid(o_valid), .i_stall(i_stall), .o_min_distance(o_min_distance)
    );

    segment_pair_min_distance_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_in_stall(o_stall),
        .i_pair(pair_q), .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_min_distance(o_min_distance), .o_fail_count(fail_count),
        .o_pending(pending), .o_checked(checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("timeout with %0d distances outstanding", pending);
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: random stalls per idle mode, or a long hold when asked
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (300) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_stall <= (idle_mode >= 2)
                    && ($urandom_range(0, 99) < ((idle_mode == 3) ? 27 : 54));
        end
    end

    // offer one request and hold it until accepted, then maybe idle
    task automatic send_pair(input logic [11:0][CW-1:0] p);
        int pct;
        pair_q  <= p;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        pairs_sent++;
        @(negedge i_clk);
        if (idle_mode == 1 || idle_mode == 3) begin
            pct = (idle_mode == 3) ? 27 : 54;
            while ($urandom_range(0, 99) < pct) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
    endtask

    function automatic logic [CW-1:0] near_coord(input int span);
        return CW'($urandom_range(0, 2*span) - span);
    endfunction

    task automatic send_random_pair();
        logic [11:0][CW-1:0] p;
        int kind, span, k;
        kind = $urandom_range(0, 9);
        span = ($urandom_range(0, 3) == 0) ? 2000000 : 4096;
        for (int i = 0; i < 12; i++)
            p[i] = (kind == 0) ? CW'($urandom) : near_coord(span);
        case (kind)
            // parallel: B direction a multiple of A direction
            1, 2: begin
                k = $urandom_range(0, 4) - 2;
                for (int i = 0; i < 3; i++)
                    p[9+i] = p[6+i] + CW'(k * ($signed(p[3+i]) - $signed(p[i])));
            end
            // collapsed segment(s)
            3: for (int i = 0; i < 3; i++) p[3+i] = p[i];
            4: for (int i = 0; i < 3; i++) p[9+i] = p[6+i];
            // shared end point
            5: for (int i = 0; i < 3; i++) p[6+i] = p[3+i];
            default: ;
        endcase
        send_pair(p);
    endtask

    initial begin
        logic [11:0][CW-1:0] p;
        logic [CW-1:0] mx, mn;
        mx = {1'b0, {(CW-1){1'b1}}};
        mn = {1'b1, {(CW-1){1'b0}}};
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        pair_q     = '0;
        idle_mode  = 0;
        hold_req   = 1'b0;
        pairs_sent = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        // directed: all zero, extremes, far apart, collapsed, crossing, parallel
        send_pair('0);
        send_pair({12{mx}});
        send_pair({12{mn}});
        send_pair({{6{mx}}, {6{mn}}});
        send_pair({{6{mn}}, {6{mx}}});
        send_pair({{3{mx}}, {3{mn}}, {3{mn}}, {3{mx}}});
        send_pair({{3{mn}}, {3{mx}}, {3{mn}}, {3{mx}}});
        p = '0; p[0] = -24'sd256; p[3] = 24'sd256; p[7] = -24'sd256; p[10] = 24'sd256;
        p[8] = 24'sd128; p[11] = 24'sd128;
        send_pair(p);                              // crossing, interior closest points
        p[6] = 24'sd1024; p[9] = 24'sd1024;
        send_pair(p);                              // s clamped to the far end
        p[6] = -24'sd1024; p[9] = -24'sd1024;
        send_pair(p);                              // s clamped to the near end
        p = '0; p[3] = 24'sd512; p[6] = 24'sd100; p[7] = 24'sd300;
        p[9] = 24'sd700; p[10] = 24'sd300;
        send_pair(p);                              // parallel, overlapping
        p[6] = 24'sd900; p[9] = 24'sd1500;
        send_pair(p);                              // parallel, t before the start
        p[6] = -24'sd900; p[9] = -24'sd600;
        send_pair(p);                              // parallel, t beyond the end
        p = '0; p[6] = 24'sd5; p[9] = 24'sd5;
        send_pair(p);                              // both collapsed
        p = '0; p[3] = 24'sd256; p[4] = 24'sd256; p[8] = 24'sd1; p[11] = 24'sd1;
        send_pair(p);
        p = {{3{mx}}, {3{24'sd0}}, {3{mn}}, {3{mx}}};
        send_pair(p);

        for (int phase = 0; phase < 4; phase++) begin
            idle_mode = phase;
            if (phase == 1) hold_req = 1'b1;
            for (int n = 0; n < 272; n++) send_random_pair();
        end
        i_valid   <= 1'b0;
        idle_mode = 0;
        while (pending != 0 || hold_req) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
        $display("sent %0d segment pairs (extremes, crossing, parallel, collapsed, random)",
                 pairs_sent);
        $display("checked %0d distances, %0d mismatches", checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
